### rtl/nsrc_pkg.sv
`default_nettype none
package nsrc_pkg;

	localparam int MAX_SEEDS = 32;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PALETTE_SIZE = 7;
	localparam int NUM_PALETTE_REGS = 7;

	localparam int COORD_W = 10;
	localparam int SLOT_W = $clog2(MAX_SEEDS);
	localparam int CNT_W = 6;
	localparam int SQ_W = 2 * COORD_W;
	localparam int DIST_W = SQ_W + 1;
	localparam int PAL_W = 3;
	localparam int COLOR_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SEED_W = 2 * COORD_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SEEDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = 3'd1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CNT_W-1:0] ACTIVE_SEEDS_RESET = 6'd20;

	localparam logic [COLOR_W-1:0] PALETTE_RESET [NUM_PALETTE_REGS] = '{
		32'hFF3449FB, 32'hFF26BBB8, 32'hFF7CC08E, 32'hFF2FBDFA,
		32'hFF98A583, 32'hFF9B86D3, 32'hFF1980FE
	};

	typedef struct packed {
		logic                done;
		logic [SLOT_W-1:0]   index;
		logic [DIST_W-1:0]   sq_dist;
		logic [PAL_W-1:0]    pal;
	} result_t;

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
			input int limit);
		logic [31:0] wide;
		wide = 32'(v);
		if (wide >= 32'(limit)) begin
			clamp_coord = COORD_W'(limit - 1);
		end else begin
			clamp_coord = v;
		end
	endfunction

endpackage
`default_nettype wire

### rtl/nsrc_ram.sv
`default_nettype none
module nsrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/nsrc_search.sv
`default_nettype none
module nsrc_search (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          query,
	input  wire logic [nsrc_pkg::COORD_W-1:0]  px,
	input  wire logic [nsrc_pkg::COORD_W-1:0]  py,
	input  wire logic [nsrc_pkg::SLOT_W-1:0]   last_index,
	output      logic                          busy,
	output      logic                          rd_en,
	output      logic [nsrc_pkg::SLOT_W-1:0]   rd_addr,
	input  wire logic [nsrc_pkg::SEED_W-1:0]   rd_data,
	output      nsrc_pkg::result_t             result
);

	import nsrc_pkg::*;

	logic                busy_q;
	logic                issue_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [PAL_W-1:0]    pal_q;
	logic [SLOT_W-1:0]   last_q;
	logic [COORD_W-1:0]  px_q;
	logic [COORD_W-1:0]  py_q;

	logic                v_s1;
	logic                last_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic [PAL_W-1:0]    pal_s1;

	logic                v_s2;
	logic                last_s2;
	logic [SLOT_W-1:0]   idx_s2;
	logic [PAL_W-1:0]    pal_s2;
	logic [DIST_W-1:0]   dist_s2;

	logic [SLOT_W-1:0]   best_idx_q;
	logic [PAL_W-1:0]    best_pal_q;
	logic [DIST_W-1:0]   best_dist_q;
	logic                res_done_q;

	logic [COORD_W-1:0]  seed_x;
	logic [COORD_W-1:0]  seed_y;
	logic [COORD_W-1:0]  dx;
	logic [COORD_W-1:0]  dy;
	logic [DIST_W-1:0]   seed_dist;
	logic                take;
	logic                issue_last;
	logic [SLOT_W-1:0]   new_idx;
	logic [PAL_W-1:0]    new_pal;
	logic [DIST_W-1:0]   new_dist;

	assign seed_x = rd_data[SEED_W-1:COORD_W];
	assign seed_y = rd_data[COORD_W-1:0];
	assign dx = (px_q >= seed_x) ? px_q - seed_x : seed_x - px_q;
	assign dy = (py_q >= seed_y) ? py_q - seed_y : seed_y - py_q;
	assign seed_dist = DIST_W'(SQ_W'(dx) * SQ_W'(dx)) + DIST_W'(SQ_W'(dy) * SQ_W'(dy));

	assign issue_last = (idx_q == last_q);
	assign rd_en = issue_q;
	assign rd_addr = idx_q;

	// lowest index wins on ties: strict less-than
	assign take = (idx_s2 == '0) || (dist_s2 < best_dist_q);
	assign new_idx = take ? idx_s2 : best_idx_q;
	assign new_pal = take ? pal_s2 : best_pal_q;
	assign new_dist = take ? dist_s2 : best_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			issue_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			res_done_q <= 1'b0;
		end else begin
			res_done_q <= 1'b0;
			if (query) begin
				busy_q <= 1'b1;
				issue_q <= 1'b1;
			end else if (issue_q && issue_last) begin
				issue_q <= 1'b0;
			end
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (v_s2 && last_s2) begin
				busy_q <= 1'b0;
				res_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query) begin
			idx_q <= '0;
			pal_q <= '0;
			last_q <= last_index;
			px_q <= px;
			py_q <= py;
		end else if (issue_q) begin
			idx_q <= idx_q + 1'b1;
			pal_q <= (pal_q == PAL_W'(PALETTE_SIZE - 1)) ? '0 : pal_q + 1'b1;
		end
		idx_s1 <= idx_q;
		pal_s1 <= pal_q;
		last_s1 <= issue_last;
		idx_s2 <= idx_s1;
		pal_s2 <= pal_s1;
		last_s2 <= last_s1;
		dist_s2 <= seed_dist;
		if (v_s2) begin
			best_idx_q <= new_idx;
			best_pal_q <= new_pal;
			best_dist_q <= new_dist;
		end
	end

	assign busy = busy_q;
	assign result = {res_done_q, best_idx_q, best_dist_q, best_pal_q};

endmodule
`default_nettype wire

### rtl/nearest_seed_region_color_unit.sv
`default_nettype none
// Nearest-seed region lookup. A beat with kind 0 stores pos_x/pos_y into seed
// table entry seed_slot and gives no result. A beat with kind 1 searches seeds
// 0 .. active_seeds-1 (0 counts as 1, above 32 as 32) one entry per cycle
// through the seed table memory read port, then presents nearest_index,
// min_distance and region_color for one cycle with done high. A query holds
// busy after the start beat until its search ends, and its result appears in
// the cycle after busy falls; the receiver cannot stall, so a result must be
// taken in the cycle done is high. Every seed searched must have been loaded
// first. Write configuration only while busy is low.
module nearest_seed_region_color_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic                             kind,
	input  wire logic [nsrc_pkg::SLOT_W-1:0]      seed_slot,
	input  wire logic [nsrc_pkg::COORD_W-1:0]     pos_x,
	input  wire logic [nsrc_pkg::COORD_W-1:0]     pos_y,
	output      logic                             done,
	output      logic [nsrc_pkg::SLOT_W-1:0]      nearest_index,
	output      logic [nsrc_pkg::DIST_W-1:0]      min_distance,
	output      logic [nsrc_pkg::COLOR_W-1:0]     region_color,
	input  wire logic                             cfg_wr_en,
	input  wire logic [nsrc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [nsrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	import nsrc_pkg::*;

	logic [CNT_W-1:0]    active_seeds_q;
	logic [COLOR_W-1:0]  palette_q [NUM_PALETTE_REGS];

	logic                accept;
	logic                load;
	logic                query;
	logic [COORD_W-1:0]  cx;
	logic [COORD_W-1:0]  cy;
	logic [SLOT_W-1:0]   last_index;
	logic                rd_en;
	logic [SLOT_W-1:0]   rd_addr;
	logic [SEED_W-1:0]   rd_data;
	logic                search_busy;
	result_t             result;

	logic                done_q;
	logic [SLOT_W-1:0]   index_q;
	logic [DIST_W-1:0]   dist_q;
	logic [COLOR_W-1:0]  color_q;

	assign accept = start && !search_busy;
	assign load = accept && (kind == KIND_LOAD);
	assign query = accept && (kind == KIND_QUERY);
	assign cx = clamp_coord(pos_x, MAX_WIDTH);
	assign cy = clamp_coord(pos_y, MAX_HEIGHT);

	always_comb begin
		if (active_seeds_q == '0) begin
			last_index = '0;
		end else if (32'(active_seeds_q) >= 32'(MAX_SEEDS)) begin
			last_index = SLOT_W'(MAX_SEEDS - 1);
		end else begin
			last_index = SLOT_W'(active_seeds_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_seeds_q <= ACTIVE_SEEDS_RESET;
			for (int i = 0; i < NUM_PALETTE_REGS; i++) begin
				palette_q[i] <= PALETTE_RESET[i];
			end
		end else if (cfg_wr_en) begin
			if (cfg_addr == CFG_ACTIVE_SEEDS) begin
				active_seeds_q <= cfg_wdata[CNT_W-1:0];
			end else begin
				palette_q[cfg_addr - CFG_PALETTE_BASE] <= cfg_wdata[COLOR_W-1:0];
			end
		end
	end

	nsrc_ram #(
		.WIDTH(SEED_W),
		.DEPTH(MAX_SEEDS)
	) u_seed_ram (
		.clk   (clk),
		.we    (load),
		.waddr (seed_slot),
		.wdata ({cx, cy}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	nsrc_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.px         (cx),
		.py         (cy),
		.last_index (last_index),
		.busy       (search_busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= result.done;
		end
	end

	// color lookup on the registered search result
	always_ff @(posedge clk) begin
		if (result.done) begin
			index_q <= result.index;
			dist_q <= result.sq_dist;
			color_q <= palette_q[result.pal];
		end
	end

	assign busy = search_busy;
	assign done = done_q;
	assign nearest_index = index_q;
	assign min_distance = dist_q;
	assign region_color = color_q;

endmodule
`default_nettype wire
